/* rtl/isl_pkg.sv */
`timescale 1ns / 1ps

package isl_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned ACT_BITS   = 3;
  localparam int unsigned INDEX_BITS = 5;
  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned COUNT_BITS = 5;
  localparam int unsigned STAT_BITS  = 2;

  localparam int unsigned IN_TDATA_BITS  = 40;
  localparam int unsigned OUT_TDATA_BITS = 40;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_READ   = 3'd0,
    ACT_PUSH   = 3'd1,
    ACT_POP    = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_REMOVE = 3'd4
  } act_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                  ins;  // open a slot at pos, load the new word there
    logic                  rem;  // close the slot at pos
    logic [INDEX_BITS-1:0] pos;
  } cell_cmd_t;

endpackage

/* rtl/isl_cell.sv */
`timescale 1ns / 1ps

module isl_cell
  import isl_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned POS       = 0
) (
  input  logic                 clk,
  input  cell_cmd_t            cmd,
  input  logic [WORD_BITS-1:0] left_word,
  input  logic [WORD_BITS-1:0] right_word,
  input  logic [WORD_BITS-1:0] load_word,
  output logic [WORD_BITS-1:0] word
);

  localparam logic [31:0] MY_POS = 32'(POS);

  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;
  logic [31:0]          pos_w;

  assign pos_w = 32'(cmd.pos);

  always_comb begin
    word_nxt = word_r;
    if (cmd.ins) begin
      if (MY_POS > pos_w) begin
        word_nxt = left_word;
      end else if (MY_POS == pos_w) begin
        word_nxt = load_word;
      end
    end else if (cmd.rem) begin
      if (MY_POS >= pos_w) begin
        word_nxt = right_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

/* rtl/isl_ctrl.sv */
`timescale 1ns / 1ps

module isl_ctrl
  import isl_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic                         fire,
  input  logic [ACT_BITS-1:0]          action,
  input  logic [INDEX_BITS-1:0]        index,
  input  logic [$clog2(DEPTH+1)-1:0]   used,
  output cell_cmd_t                    cmd,
  output status_t                      status,
  output logic                         read_ok,
  output logic [$clog2(DEPTH+1)-1:0]   used_nxt
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [KW-1:0] idx_k;
  logic [KW-1:0] used_k;
  logic          is_empty;
  logic          is_full;
  act_t          act;

  assign idx_k    = KW'(index);
  assign used_k   = KW'(used);
  assign is_empty = (used == '0);
  assign is_full  = (used >= FULL_CNT);
  assign act      = act_t'(action);

  always_comb begin
    status   = ST_OK;
    read_ok  = 1'b0;
    used_nxt = used;
    cmd.ins  = 1'b0;
    cmd.rem  = 1'b0;
    cmd.pos  = index;
    case (act)
      ACT_READ: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (idx_k >= used_k) begin
          status = ST_BAD_INDEX;
        end else begin
          read_ok = 1'b1;
        end
      end
      ACT_PUSH: begin
        if (is_full) begin
          status = ST_FULL;
        end else begin
          // append is an insert at the current end
          cmd.ins  = fire;
          cmd.pos  = INDEX_BITS'(used);
          used_nxt = used + CW'(1);
        end
      end
      ACT_POP: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else begin
          used_nxt = used - CW'(1);
        end
      end
      ACT_INSERT: begin
        if (is_full) begin
          status = ST_FULL;
        end else if (idx_k > used_k) begin
          status = ST_BAD_INDEX;
        end else begin
          cmd.ins  = fire;
          used_nxt = used + CW'(1);
        end
      end
      ACT_REMOVE: begin
        if (is_empty) begin
          status = ST_EMPTY;
        end else if (idx_k >= used_k) begin
          status = ST_BAD_INDEX;
        end else begin
          cmd.rem  = fire;
          used_nxt = used - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/indexed_shift_list_top.sv */
`timescale 1ns / 1ps

// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      tdata: action[2:0] index[7:3] data[39:8]
// out_     out  tvalid/tready      tdata: read_data[31:0] count[36:32] status[38:37]
//
// One request per cycle while in_tready is high: each beat is decoded against the held count and
// applied to the whole cell chain in the cycle it is accepted.
// The result lands in an output register in the cycle after the input beat.
// A new input beat is taken while the held result is being taken, so
// a stall on out_ holds in_tready low only while the result register is full.
// Synchronous active-low reset clears the count and the output valid flag;
// the stored words have no reset and are only read below the count.

module indexed_shift_list_top
  import isl_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_BITS-1:0]  in_tdata,   // action, index, data (from bit 0 up)
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_BITS-1:0] out_tdata   // read_data, count, status, zero pad
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  // unpack the input beat
  logic [ACT_BITS-1:0]   in_action;
  logic [INDEX_BITS-1:0] in_index;
  logic [DATA_BITS-1:0]  in_data;

  assign in_action = in_tdata[ACT_BITS-1:0];
  assign in_index  = in_tdata[ACT_BITS+INDEX_BITS-1:ACT_BITS];
  assign in_data   = in_tdata[ACT_BITS+INDEX_BITS+DATA_BITS-1:ACT_BITS+INDEX_BITS];

  // control state
  logic [CW-1:0] used_r;
  logic [CW-1:0] used_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          fire;

  // result register, no reset
  logic [DATA_BITS-1:0]  out_read_data_r;
  logic [DATA_BITS-1:0]  out_read_data_nxt;
  logic [COUNT_BITS-1:0] out_count_r;
  status_t               out_status_r;

  cell_cmd_t cmd;
  status_t   status;
  logic      read_ok;
  logic [CW-1:0] used_dec;

  // accept whenever the result slot is free or being drained this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  isl_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .fire     (fire),
    .action   (in_action),
    .index    (in_index),
    .used     (used_r),
    .cmd      (cmd),
    .status   (status),
    .read_ok  (read_ok),
    .used_nxt (used_dec)
  );

  // word to load, masked to the stored width
  logic [63:0]          data_ext;
  logic [WORD_BITS-1:0] load_word;

  assign data_ext  = 64'(in_data);
  assign load_word = data_ext[WORD_BITS-1:0];

  // chain of cells: each inner cell talks to its two neighbors, the end cells to one
  logic [WORD_BITS-1:0] words [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w;
    logic [WORD_BITS-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = words[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = words[g+1];
    end

    isl_cell #(
      .WORD_BITS (WORD_BITS),
      .POS       (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_word  (left_w),
      .right_word (right_w),
      .load_word  (load_word),
      .word       (words[g])
    );
  end

  // read tap: only taken when the index is below the count
  logic [IW-1:0]        rd_sel;
  logic [WORD_BITS-1:0] rd_word;
  logic [63:0]          rd_ext;

  assign rd_sel  = IW'(in_index);
  assign rd_word = words[rd_sel];
  assign rd_ext  = 64'(rd_word);

  always_comb begin
    used_nxt          = fire ? used_dec : used_r;
    out_valid_nxt     = fire ? 1'b1 : (out_valid_r && !out_tready);
    out_read_data_nxt = read_ok ? rd_ext[DATA_BITS-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the result on each accepted beat, hold otherwise
  always_ff @(posedge clk) begin
    if (fire) begin
      out_read_data_r <= out_read_data_nxt;
      out_count_r     <= COUNT_BITS'(used_dec);
      out_status_r    <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {
    (OUT_TDATA_BITS - DATA_BITS - COUNT_BITS - STAT_BITS)'(0),
    out_status_r,
    out_count_r,
    out_read_data_r
  };

  // count never passes the capacity
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(DEPTH))
    else $error("list count beyond capacity");

  // a rejected request leaves the count alone
  a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status != ST_OK) |=> $stable(used_r))
    else $error("rejected request changed the count");

  // an accepted push grows the list by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (status == ST_OK) && (act_t'(in_action) == ACT_PUSH)
      |=> used_r == $past(used_r) + CW'(1))
    else $error("push did not grow the count");

  // read data only carries a word with an ok status
  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_read_data_r == '0)
    else $error("read data on a failed request");

endmodule
